### src/sawbc_pkg.sv
package sawbc_pkg;

    localparam int CACHE_BYTES_DEF = 1024;
    localparam int WAYS_DEF        = 4;
    localparam int LINE_BYTES_DEF  = 16;
    localparam int ADDR_W          = 32;
    localparam int DATA_W          = 8;
    localparam int KIND_W          = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FILL  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [KIND_W-1:0] {
        RES_DONE  = 2'd0,
        RES_WBACK = 2'd1,
        RES_FREQ  = 2'd2,
        RES_UNUSED = 2'd3
    } res_kind_t;

    // One input item as it travels from the front part to the back part.
    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  write_data;
        logic [DATA_W-1:0]  fill_data;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

endpackage

### src/sawbc_front.sv
module sawbc_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sawbc_pkg::item_t       s_item,
    output logic                   q_valid,
    input  logic                   q_ready,
    output sawbc_pkg::item_t       q_item
);

    localparam int DEPTH = 2;

    sawbc_pkg::item_t buf_reg [DEPTH];
    logic             wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    // Items of kind three never reach the back part.
    assign s_ready = (cnt_reg != 2'(DEPTH));
    assign push    = s_valid && s_ready && (s_item.kind != sawbc_pkg::KIND_NONE);
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_item  = buf_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wp_reg] <= s_item;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(DEPTH)) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'(DEPTH)) |-> !s_ready) else $error("accept when full");
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("pop bookkeeping");

endmodule

### src/sawbc_back.sv
module sawbc_back #(
    parameter int CACHE_BYTES = sawbc_pkg::CACHE_BYTES_DEF,
    parameter int WAYS        = sawbc_pkg::WAYS_DEF,
    parameter int LINE_BYTES  = sawbc_pkg::LINE_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  sawbc_pkg::item_t              q_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sawbc_pkg::KIND_W-1:0]  m_kind,
    output logic [sawbc_pkg::ADDR_W-1:0]  m_address,
    output logic [sawbc_pkg::DATA_W-1:0]  m_data,
    output logic                          m_hit,
    output logic                          m_last
);

    localparam int NL_RAW = CACHE_BYTES / LINE_BYTES;
    localparam int NSETS  = (NL_RAW / WAYS) > 0 ? (NL_RAW / WAYS) : 1;
    localparam int NLINES = NSETS * WAYS;
    localparam int OB     = $clog2(LINE_BYTES);
    localparam int IB     = $clog2(NSETS);
    localparam int WB     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LB     = (NLINES > 1) ? $clog2(NLINES) : 1;
    localparam int SB     = (NSETS > 1) ? $clog2(NSETS) : 1;
    localparam int OBW    = (OB > 0) ? OB : 1;
    localparam int TW     = sawbc_pkg::ADDR_W - OB - IB;
    localparam int TWW    = (TW > 0) ? TW : 1;
    localparam int CB     = $clog2(LINE_BYTES + 1);
    localparam int DW     = sawbc_pkg::DATA_W;
    localparam int AW     = sawbc_pkg::ADDR_W;
    localparam int MB     = (NLINES * LINE_BYTES > 1) ? $clog2(NLINES * LINE_BYTES) : 1;
    localparam int SPOW   = 1 << IB;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOOK  = 7'b0000010,
        ST_WBRD  = 7'b0000100,
        ST_WBOUT = 7'b0001000,
        ST_REQ   = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_FILL  = 7'b1000000
    } state_t;

    state_t                     st_reg, st_next;
    logic [NLINES-1:0]          valid_reg, dirty_reg;
    logic [WB-1:0]              lru_reg [NSETS][WAYS];
    logic [WAYS-1:0][TWW-1:0]   tag_mem [NSETS];
    logic [DW-1:0]              data_mem [NLINES*LINE_BYTES];

    sawbc_pkg::item_t           cur_reg;
    logic                       wr_reg;
    logic                       pend_reg;
    logic [CB-1:0]              cnt_reg;
    logic [WB-1:0]              way_reg;
    logic                       hit_reg;
    logic [WAYS-1:0][TWW-1:0]   tagrd_reg;
    logic [TWW-1:0]             vtag_reg;
    logic [DW-1:0]              rd_reg;

    logic [SB-1:0]     set_c;
    logic [TWW-1:0]    tag_c;
    logic [OBW-1:0]    off_c;
    logic [AW-1:0]     off_raw;

    // Set index of an address, reduced into range when the set count is not a power of two.
    function automatic logic [SB-1:0] set_of(logic [AW-1:0] a);
        logic [AW-1:0] s;
        s = (a >> OB) & AW'(SPOW - 1);
        if (s >= AW'(NSETS))
            s = s - AW'(NSETS);
        return SB'(s);
    endfunction

    assign set_c   = set_of(cur_reg.address);
    assign tag_c   = (TW > 0) ? TWW'(cur_reg.address >> (OB + IB)) : '0;
    assign off_raw = cur_reg.address & AW'((1 << OB) - 1);
    assign off_c   = (off_raw >= AW'(LINE_BYTES)) ? OBW'(off_raw - AW'(LINE_BYTES))
                                                  : OBW'(off_raw);

    function automatic logic [LB-1:0] lidx(logic [SB-1:0] s, logic [WB-1:0] w);
        return LB'(32'(s) * WAYS + 32'(w));
    endfunction

    function automatic logic [MB-1:0] bidx(logic [LB-1:0] l, logic [CB-1:0] o);
        return MB'(32'(l) * LINE_BYTES + 32'(o));
    endfunction

    // Hit search, in the lookup state, over the tag row read at dequeue.
    logic          hit_c;
    logic [WB-1:0] hway_c, vway_c;
    logic          inv_c;
    always_comb begin
        hit_c  = 1'b0;
        hway_c = '0;
        inv_c  = 1'b0;
        vway_c = lru_reg[set_c][WAYS-1];
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (valid_reg[lidx(set_c, WB'(w))] && tagrd_reg[w] == tag_c) begin
                hit_c  = 1'b1;
                hway_c = WB'(w);
            end
            if (!valid_reg[lidx(set_c, WB'(w))]) begin
                inv_c  = 1'b1;
                vway_c = WB'(w);
            end
        end
    end

    logic is_fill, is_acc;
    assign is_fill = (cur_reg.kind == sawbc_pkg::KIND_FILL);
    assign is_acc  = !is_fill;

    logic out_free;
    assign out_free = !m_valid || m_ready;
    assign q_ready  = (st_reg == ST_IDLE);

    logic [LB-1:0] li_c;
    assign li_c = lidx(set_c, way_reg);

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (q_valid) st_next = ST_LOOK;
            ST_LOOK: begin
                if (is_fill) begin
                    st_next = pend_reg ? ST_FILL : ST_IDLE;
                end else if (pend_reg) begin
                    st_next = ST_IDLE;
                end else if (hit_c) begin
                    st_next = ST_DONE;
                end else if (!inv_c && valid_reg[lidx(set_c, vway_c)]
                             && dirty_reg[lidx(set_c, vway_c)]) begin
                    st_next = ST_WBRD;
                end else begin
                    st_next = ST_REQ;
                end
            end
            ST_WBRD:  st_next = ST_WBOUT;
            ST_WBOUT: if (out_free) begin
                st_next = (cnt_reg == CB'(LINE_BYTES - 1)) ? ST_REQ : ST_WBRD;
            end
            ST_REQ:   if (out_free) st_next = ST_IDLE;
            ST_FILL:  st_next = (cnt_reg == CB'(LINE_BYTES - 1)) ? ST_DONE : ST_IDLE;
            ST_DONE:  if (out_free) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    logic wb_out, out_load;
    assign wb_out   = (st_reg == ST_WBOUT) && out_free;
    assign out_load = out_free &&
                      (st_reg == ST_WBOUT || st_reg == ST_REQ || st_reg == ST_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            way_reg   <= '0;
            hit_reg   <= 1'b0;
            m_valid   <= 1'b0;
            for (int s = 0; s < NSETS; s++)
                for (int w = 0; w < WAYS; w++)
                    lru_reg[s][w] <= WB'(w);
        end else begin
            st_reg <= st_next;
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (st_reg)
                ST_LOOK: begin
                    if (is_acc && !pend_reg) begin
                        cnt_reg <= '0;
                        if (hit_c) begin
                            way_reg <= hway_c;
                            hit_reg <= 1'b1;
                        end else begin
                            way_reg <= vway_c;
                            hit_reg <= 1'b0;
                            valid_reg[lidx(set_c, vway_c)] <= 1'b0;
                            dirty_reg[lidx(set_c, vway_c)] <= 1'b0;
                            vtag_reg <= tagrd_reg[vway_c];
                        end
                    end
                end
                ST_WBOUT: if (out_free) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_REQ: if (out_free) begin
                    pend_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
                ST_FILL: begin
                    if (cnt_reg == CB'(LINE_BYTES - 1)) begin
                        valid_reg[li_c] <= 1'b1;
                        dirty_reg[li_c] <= 1'b0;
                        pend_reg <= 1'b0;
                        cnt_reg  <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DONE: if (out_free) begin
                    if (wr_reg) dirty_reg[li_c] <= 1'b1;
                    begin : touch
                        logic hit_seen;
                        hit_seen = 1'b0;
                        for (int i = WAYS - 1; i > 0; i--) begin
                            if (lru_reg[set_c][i] == way_reg) hit_seen = 1'b1;
                            if (hit_seen) lru_reg[set_c][i] <= lru_reg[set_c][i-1];
                        end
                        lru_reg[set_c][0] <= way_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // Storage reads and writes. At dequeue the tag row of the item's set is read;
    // an access that starts a miss keeps its address and data until the fill ends.
    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && q_valid) begin
            cur_reg.kind      <= q_item.kind;
            cur_reg.fill_data <= q_item.fill_data;
            if (q_item.kind != sawbc_pkg::KIND_FILL && !pend_reg) begin
                cur_reg.address    <= q_item.address;
                cur_reg.write_data <= q_item.write_data;
                wr_reg             <= (q_item.kind == sawbc_pkg::KIND_WRITE);
            end
            tagrd_reg <= tag_mem[set_of(q_item.address)];
        end
        if (st_reg == ST_WBRD)
            rd_reg <= data_mem[bidx(li_c, cnt_reg)];
        if (st_reg == ST_FILL)
            data_mem[bidx(li_c, cnt_reg)] <= cur_reg.fill_data;
        if (st_reg == ST_FILL && cnt_reg == CB'(LINE_BYTES - 1))
            tag_mem[set_c][way_reg] <= tag_c;
        if (st_reg == ST_DONE && out_free && wr_reg)
            data_mem[bidx(li_c, CB'(off_c))] <= cur_reg.write_data;
    end

    logic [AW-1:0] wb_base;
    assign wb_base = (AW'(vtag_reg) << (OB + IB)) | (AW'(set_c) << OB);

    always_ff @(posedge aclk) begin
        if (wb_out) begin
            m_kind    <= sawbc_pkg::RES_WBACK;
            m_address <= wb_base + AW'(cnt_reg);
            m_data    <= rd_reg;
            m_hit     <= 1'b0;
            m_last    <= 1'b0;
        end else if (st_reg == ST_REQ && out_free) begin
            m_kind    <= sawbc_pkg::RES_FREQ;
            m_address <= cur_reg.address & ~AW'((1 << OB) - 1);
            m_data    <= '0;
            m_hit     <= 1'b0;
            m_last    <= 1'b1;
        end else if (st_reg == ST_DONE && out_free) begin
            m_kind    <= sawbc_pkg::RES_DONE;
            m_address <= cur_reg.address;
            m_data    <= wr_reg ? '0 : data_mem[bidx(li_c, CB'(off_c))];
            m_hit     <= hit_reg;
            m_last    <= 1'b1;
        end
    end

    a_pend_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DONE) |-> (pend_reg == 1'b0)) else $error("done while fill pending");
    a_req_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == sawbc_pkg::RES_FREQ) |-> m_last) else $error("request not last");
    a_wb_notlast: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == sawbc_pkg::RES_WBACK) |-> !m_last) else $error("wb marked last");

endmodule

### src/set_assoc_write_back_cache_unit.sv
// Channel  | Direction | tdata fields (low bit up)               | tuser
// s_axis   | in        | address[31:0], write_data[39:32],        | kind[1:0]
//          |           | fill_data[47:40]                         |
// m_axis   | out       | out_address[31:0], out_data[39:32],      | result_kind[1:0],
//          |           | was_hit[40]                              | tlast = last
//
// A transfer enters a two-entry queue and is then taken by the back part, which
// works on one item at a time: a hit passes through dequeue with the tag row read,
// compare and data access, a dirty miss adds a store read and an output step for
// each write-back byte, and a fill byte passes dequeue, compare and a store write.
// The data store is single-ported. Reset is synchronous and active low; it clears
// valid and dirty bits at once, so no clearing pass is needed. A stalled result
// holds the back part, while the queue keeps taking transfers until it is full.
module set_assoc_write_back_cache_unit #(
    parameter int CACHE_BYTES = sawbc_pkg::CACHE_BYTES_DEF,
    parameter int WAYS        = sawbc_pkg::WAYS_DEF,
    parameter int LINE_BYTES  = sawbc_pkg::LINE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // address, write_data, fill_data
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_address, out_data, was_hit, zero pad
    output logic [1:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast
);

    sawbc_pkg::item_t s_item, q_item;
    logic             q_valid, q_ready;
    logic [31:0]      m_address;
    logic [7:0]       m_data;
    logic             m_hit;

    // The kind field is cast into the package enum for the queue.
    assign s_item.kind       = sawbc_pkg::kind_t'(s_axis_tuser);
    assign s_item.address    = s_axis_tdata[31:0];
    assign s_item.write_data = s_axis_tdata[39:32];
    assign s_item.fill_data  = s_axis_tdata[47:40];

    sawbc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    sawbc_back #(
        .CACHE_BYTES (CACHE_BYTES),
        .WAYS        (WAYS),
        .LINE_BYTES  (LINE_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_kind    (m_axis_tuser),
        .m_address (m_address),
        .m_data    (m_data),
        .m_hit     (m_hit),
        .m_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, m_hit, m_data, m_address};

endmodule
